// ===== design/bds_pkg.sv =====
// Shared types and constants for the 2x2 box-average downscaler.
package bds_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int PORT_BITS   = 16;
  localparam int WIDTH_BITS  = 13;
  localparam int HEIGHT_BITS = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_SAMPLE_SIGNED = 2'd2
  } cfg_index_t;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd4096;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1;

  typedef struct packed {
    logic emit;
    logic store;
    logic only_row;
    logic last;
  } scan_ctl_t;

endpackage

// ===== design/bds_line_mem.sv =====
// Line store holding the horizontal pair sums of the upper row of a row pair.
module bds_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 18
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/bds_scan.sv =====
// Raster position counters, horizontal pair accumulation and block decisions.
module bds_scan
  import bds_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int CW         = 12,
  parameter int AW         = 11,
  parameter int SW         = PIXEL_BITS + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [PIXEL_BITS-1:0]  sample,
  input  logic                   sample_signed,
  input  logic [CW-1:0]          last_col,
  input  logic [HEIGHT_BITS-1:0] last_row,
  output scan_ctl_t              ctl,
  output logic [SW-1:0]          pair_next,
  output logic [AW-1:0]          slot
);

  logic [CW-1:0]          column_count;
  logic [HEIGHT_BITS-1:0] row_count;
  logic [SW-1:0]          pair_sum;
  logic [SW-1:0]          p;
  logic                   row_end;
  logic                   frame_end;
  logic                   lower_row;
  logic                   pair_done;
  logic                   out_row;

  always_comb begin
    p = {{2{sample_signed & sample[PIXEL_BITS-1]}}, sample};
    row_end   = column_count >= last_col;
    frame_end = row_count >= last_row;
    lower_row = row_count[0];
    ctl.only_row = !lower_row && frame_end;
    out_row = lower_row || ctl.only_row;
    if (!column_count[0]) begin
      pair_next = row_end ? (p + p) : p;
      pair_done = row_end;
    end else begin
      pair_next = pair_sum + p;
      pair_done = 1'b1;
    end
    ctl.emit  = pair_done && out_row;
    ctl.store = pair_done && !out_row;
    ctl.last  = row_end && frame_end;
    slot = AW'(column_count >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pair_sum     <= '0;
    end else if (accept) begin
      pair_sum <= pair_next;
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule

// ===== design/box_downscale_2x2.sv =====
// Top level of the streaming 2x2 box-average image downscaler.
// Pixels enter one per transaction in raster order and every 2x2 block gives one
// averaged output pixel (odd widths and heights repeat the last column or row);
// the final output of a frame carries last_of_frame. One pixel is taken every
// clock cycle unless out_ready back-pressure stalls it; a result is registered
// by the read of the single-port-per-side line store, then by the output register.
// The line store needs no clearing after reset. The user must write configuration
// only while the block is idle; the block itself does not enforce it.
module box_downscale_2x2
  import bds_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    pixel_valid,
  output logic                    pixel_ready,
  input  logic [PORT_BITS-1:0]    pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PORT_BITS-1:0]    out_pixel,
  output logic                    last_of_frame
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int SW = PIXEL_BITS + 2;

  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic                   sample_signed;

  logic [31:0]            width_ext;
  logic [31:0]            last_col_ext;
  logic [CW-1:0]          last_col;
  logic [HEIGHT_BITS-1:0] last_row;

  scan_ctl_t              ctl;
  logic [SW-1:0]          pair_next;
  logic [AW-1:0]          slot;
  logic [SW-1:0]          rd_data;
  logic                   accept;
  logic                   advance;

  logic                   s1_valid;
  logic [SW-1:0]          s1_pair;
  logic                   s1_only;
  logic                   s1_last;
  logic [SW-1:0]          total;
  logic [SW-1:0]          adjusted;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      sample_signed <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data[HEIGHT_BITS-1:0];
        CFG_SAMPLE_SIGNED: sample_signed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_ext = {{(32 - WIDTH_BITS){1'b0}}, image_width};
    if (width_ext == 32'd0) begin
      last_col_ext = 32'd0;
    end else if (width_ext > 32'(MAX_WIDTH)) begin
      last_col_ext = 32'(MAX_WIDTH - 1);
    end else begin
      last_col_ext = width_ext - 32'd1;
    end
    last_col = CW'(last_col_ext);
    last_row = (image_height == '0) ? '0 : image_height - 1'b1;
  end

  assign advance     = !out_valid || out_ready;
  assign pixel_ready = !s1_valid || advance;
  assign accept      = pixel_valid && pixel_ready;

  bds_scan #(
    .PIXEL_BITS (PIXEL_BITS),
    .CW         (CW),
    .AW         (AW),
    .SW         (SW)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample        (pixel[PIXEL_BITS-1:0]),
    .sample_signed (sample_signed),
    .last_col      (last_col),
    .last_row      (last_row),
    .ctl           (ctl),
    .pair_next     (pair_next),
    .slot          (slot)
  );

  bds_line_mem #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW),
    .DW    (SW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (accept && ctl.store),
    .wr_addr (slot),
    .wr_data (pair_next),
    .rd_en   (accept && ctl.emit),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= ctl.emit;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctl.emit) begin
      s1_pair <= pair_next;
      s1_only <= ctl.only_row;
      s1_last <= ctl.last;
    end
  end

  // Signed averages round toward zero, so negative sums are biased by three.
  always_comb begin
    total    = s1_only ? (s1_pair + s1_pair) : (s1_pair + rd_data);
    adjusted = (sample_signed && total[SW-1]) ? total + SW'(3) : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_pixel     <= PORT_BITS'(adjusted[SW-1:2]);
      last_of_frame <= s1_last;
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the box_downscale_2x2 2x2 box-average downscaler.
module tb
  import bds_pkg::*;
();

  typedef struct {
    logic [PORT_BITS-1:0] value;
    logic                 last;
  } avg_pixel_t;

  class box_scoreboard;
    int         width_reg;
    int         height_reg;
    bit         signed_mode;
    int         line_sums [2048];
    int         partial_sum;
    int         col;
    int         row;
    avg_pixel_t pending [$];
    int         errors;
    int         pixels_in;
    int         pixels_out;
    int         frames_out;

    function new();
      width_reg = 4096;
      height_reg = 1;
      signed_mode = 0;
      foreach (line_sums[i]) line_sums[i] = 0;
      partial_sum = 0;
      col = 0;
      row = 0;
      errors = 0;
      pixels_in = 0;
      pixels_out = 0;
      frames_out = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_BITS-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH: begin
          width_reg = data[WIDTH_BITS-1:0];
        end
        CFG_IMAGE_HEIGHT: begin
          height_reg = data[HEIGHT_BITS-1:0];
        end
        CFG_SAMPLE_SIGNED: begin
          signed_mode = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    function int row_length();
      if (width_reg == 0) return 1;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    // The upper row of each row pair leaves horizontal pair sums in the line
    // store; the lower row completes them, and a lone last row is counted twice.
    function void note_pixel(logic [PORT_BITS-1:0] raw);
      int         w;
      int         h;
      int         p;
      int         slot;
      int         total;
      int         avg;
      bit         row_end;
      bit         frame_end;
      bit         lower;
      bit         only;
      bit         done;
      avg_pixel_t r;
      w = row_length();
      h = (height_reg == 0) ? 1 : height_reg;
      p = (signed_mode && raw[PORT_BITS-1]) ? int'(raw) - 65536 : int'(raw);
      row_end = (col >= w - 1);
      frame_end = (row >= h - 1);
      lower = row[0];
      only = !lower && frame_end;
      if (!col[0]) begin
        partial_sum = row_end ? 2 * p : p;
        done = row_end;
      end else begin
        partial_sum += p;
        done = 1;
      end
      if (done) begin
        slot = col >> 1;
        if (slot > 2047) slot = 2047;
        if (lower || only) begin
          total = only ? 2 * partial_sum : partial_sum + line_sums[slot];
          avg = signed_mode ? total / 4 : total >> 2;
          r.value = avg[PORT_BITS-1:0];
          r.last = row_end && frame_end;
          pending.push_back(r);
        end else begin
          line_sums[slot] = partial_sum;
        end
      end
      if (row_end) begin
        col = 0;
        row = frame_end ? 0 : row + 1;
      end else begin
        col++;
      end
      pixels_in++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH: %s", msg);
    endtask

    task check_output(logic [PORT_BITS-1:0] value, logic last);
      avg_pixel_t r;
      if (pending.size() == 0) begin
        report($sformatf("output pixel %h with nothing outstanding", value));
        return;
      end
      r = pending.pop_front();
      if (value !== r.value)
        report($sformatf("out_pixel %h, predicted %h (result %0d)", value, r.value, pixels_out));
      if (last !== r.last)
        report($sformatf("last_of_frame %b, predicted %b (result %0d)", last, r.last,
                         pixels_out));
      pixels_out++;
      if (last) frames_out++;
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    pixel_valid = 1'b0;
  logic                    pixel_ready;
  logic [PORT_BITS-1:0]    pixel = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [PORT_BITS-1:0]    out_pixel;
  logic                    last_of_frame;

  box_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  pressure_go = 1'b0;
  bit  pressure_done = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  box_downscale_2x2 dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel         (pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel),
    .last_of_frame (last_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_output(out_pixel, last_of_frame);
      if (pressure_go && !pressure_done) begin
        hold_left = 300;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= 5000) begin
      $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("box_downscale_2x2 verification failed");
      $finish;
    end
  end

  function automatic logic [PORT_BITS-1:0] pick_pixel();
    case ($urandom_range(15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [PORT_BITS-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      pixel <= 16'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pixel_valid <= 1'b1;
    pixel <= value;
    do @(posedge clk); while (!pixel_ready);
    sb.note_pixel(value);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input int w, input int h, input bit s);
    write_reg(CFG_IMAGE_WIDTH, {3'($urandom), 13'(w)});
    write_reg(CFG_IMAGE_HEIGHT, 16'(h));
    write_reg(CFG_SAMPLE_SIGNED, {15'($urandom), s});
    cfg_we <= 1'b0;
  endtask

  // Registers may only change once the block has drained.
  task automatic settle();
    pixel_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_rows(input int w, input int h, input bit s, input int rows);
    int len;
    settle();
    configure(w, h, s);
    len = sb.row_length();
    repeat (rows * len) send_pixel(pick_pixel());
  endtask

  initial begin
    int w;
    int h;
    int frames;
    int start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    configure(2, 2, 0);
    repeat (4) send_pixel(16'hFFFF);
    settle();
    configure(2, 2, 1);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    repeat (4) send_pixel(16'h8000);
    settle();
    configure(3, 3, 0);
    repeat (9) send_pixel(pick_pixel());
    settle();
    configure(0, 0, 1);
    send_pixel(16'h8001);

    send_idle_pct = 24;
    recv_idle_pct = 60;
    run_rows(301, 2, 0, 2);
    run_rows(95, 1, 1, 1);
    run_rows(2, 65535, 1, 4);
    run_rows(2, 5, 1, 1);

    pressure_go <= 1'b1;
    run_rows(16, 8, 0, 8);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 60 : 0;
      recv_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 24 : 0;
      start = sb.pixels_in;
      while (sb.pixels_in - start < 320) begin
        case ($urandom_range(19))
          0: w = 0;
          1: w = $urandom_range(41, 300);
          2, 3, 4, 5: w = $urandom_range(9, 40);
          default: w = $urandom_range(1, 8);
        endcase
        case ($urandom_range(9))
          0: h = 0;
          1: h = $urandom_range(7, 12);
          default: h = $urandom_range(1, 6);
        endcase
        frames = $urandom_range(1, 3);
        if (w > 40) begin
          frames = 1;
          h = $urandom_range(1, 3);
        end
        run_rows(w, h, $urandom_range(1), frames * ((h == 0) ? 1 : h));
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input pixels and %0d averaged outputs over %0d frames,",
             sb.pixels_in, sb.pixels_out, sb.frames_out);
    $display("with signed and unsigned samples, odd and even sizes, and widths up to 301.");
    if (sb.errors == 0) begin
      $display("box_downscale_2x2 verification clean");
    end else begin
      $display("box_downscale_2x2 verification failed");
    end
    $finish;
  end

endmodule

// ===== box_downscale_2x2.f =====
design/bds_pkg.sv
design/bds_line_mem.sv
design/bds_scan.sv
design/box_downscale_2x2.sv
bench/tb.sv
